>>> rtl/bytea_text_decoder_core_assert.svh
// Assertion macros used by the byte-string decoder RTL.
// Depends on nothing; included by the decoder core to check its own logic.
`ifndef BYTEA_TEXT_DECODER_CORE_ASSERT_SVH
`define BYTEA_TEXT_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BYTD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BYTD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bytd_pkg.sv
// Types, constants and the digit table for the byte-string text decoder.
// Depends on nothing; used by all decoder modules and the testbench.
package bytd_pkg;

   localparam logic [7:0] BSLASH    = 8'h5C;
   localparam logic [7:0] LOWER_X   = 8'h78;
   localparam logic [5:0] NOT_DIGIT = 6'd37;
   localparam logic [5:0] OCT_LIMIT = 6'd8;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_LEADBS = 3'd1,
      PH_HEXHI  = 3'd2,
      PH_HEXLO  = 3'd3,
      PH_PLAIN  = 3'd4,
      PH_ESC1   = 3'd5,
      PH_ESC2   = 3'd6,
      PH_ESC3   = 3'd7
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] partial;
      logic       failed;
   } state_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] out_data;
      logic       byte_present;
      logic       value_end;
      logic       bad_value;
   } result_type;

   // Digits give 0-9, letters of either case give 10-35, anything else 37.
   function automatic logic [5:0] digit_value(input logic [7:0] c);
      logic [5:0] v;
      if (c inside {[8'h30:8'h39]}) begin
         v = 6'(c - 8'h30);
      end else if (c inside {[8'h41:8'h5A]}) begin
         v = 6'(c - 8'h41 + 8'd10);
      end else if (c inside {[8'h61:8'h7A]}) begin
         v = 6'(c - 8'h61 + 8'd10);
      end else begin
         v = NOT_DIGIT;
      end
      return v;
   endfunction

endpackage

>>> rtl/bytd_chan_if.sv
// Valid/ready channel interfaces for characters in and decoded results out.
// Depends on nothing.
interface bytd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_final;

   modport source (output valid, output in_char, output in_final, input ready);
   modport sink   (input valid, input in_char, input in_final, output ready);
endinterface

interface bytd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_data;
   logic       byte_present;
   logic       value_end;
   logic       bad_value;

   modport source (output valid, output out_data, output byte_present,
                   output value_end, output bad_value, input ready);
   modport sink   (input valid, input out_data, input byte_present,
                   input value_end, input bad_value, output ready);
endinterface

>>> rtl/bytd_step.sv
// Per-character next-state and result logic of the byte-string decoder.
// Depends on bytd_pkg.
module bytd_step (
   input  bytd_pkg::state_type  cur_state,
   input  logic [7:0]           in_char,
   input  logic                 in_final,
   output bytd_pkg::state_type  nxt_state,
   output bytd_pkg::result_type result
);

   logic [5:0]          dv;
   logic                have;
   logic [7:0]          byte_val;
   bytd_pkg::state_type upd;
   logic                bad;

   assign dv = bytd_pkg::digit_value(in_char);

   always_comb begin
      upd      = cur_state;
      have     = 1'b0;
      byte_val = 8'h00;
      if (!cur_state.failed) begin
         case (cur_state.phase)
            bytd_pkg::PH_START: begin
               if (in_char == bytd_pkg::BSLASH) begin
                  upd.phase = bytd_pkg::PH_LEADBS;
               end else begin
                  have      = 1'b1;
                  byte_val  = in_char;
                  upd.phase = bytd_pkg::PH_PLAIN;
               end
            end
            bytd_pkg::PH_HEXHI: begin
               upd.partial = {dv[3:0], 4'h0};
               upd.phase   = bytd_pkg::PH_HEXLO;
            end
            bytd_pkg::PH_HEXLO: begin
               have      = 1'b1;
               byte_val  = cur_state.partial | {2'b00, dv};
               upd.phase = bytd_pkg::PH_HEXHI;
            end
            bytd_pkg::PH_ESC2: begin
               if (dv < bytd_pkg::OCT_LIMIT) begin
                  upd.partial = {cur_state.partial[4:0], dv[2:0]};
                  upd.phase   = bytd_pkg::PH_ESC3;
               end else begin
                  upd.failed = 1'b1;
               end
            end
            bytd_pkg::PH_ESC3: begin
               if (dv < bytd_pkg::OCT_LIMIT) begin
                  have      = 1'b1;
                  byte_val  = {cur_state.partial[4:0], dv[2:0]};
                  upd.phase = bytd_pkg::PH_PLAIN;
               end else begin
                  upd.failed = 1'b1;
               end
            end
            bytd_pkg::PH_PLAIN: begin
               if (in_char == bytd_pkg::BSLASH) begin
                  upd.phase = bytd_pkg::PH_ESC1;
               end else begin
                  have     = 1'b1;
                  byte_val = in_char;
               end
            end
            default: begin
               // Leading backslash or an escape opener: an 'x' only matters
               // right at the start of the value.
               if (cur_state.phase == bytd_pkg::PH_LEADBS && in_char == bytd_pkg::LOWER_X) begin
                  upd.phase = bytd_pkg::PH_HEXHI;
               end else if (dv < bytd_pkg::OCT_LIMIT) begin
                  upd.partial = {5'b00000, dv[2:0]};
                  upd.phase   = bytd_pkg::PH_ESC2;
               end else if (in_char == bytd_pkg::BSLASH) begin
                  have      = 1'b1;
                  byte_val  = bytd_pkg::BSLASH;
                  upd.phase = bytd_pkg::PH_PLAIN;
               end else begin
                  upd.failed = 1'b1;
               end
            end
         endcase
      end

      // Once the value has failed, no more bytes are emitted for it.
      if (upd.failed) begin
         have     = 1'b0;
         byte_val = 8'h00;
      end

      bad = upd.failed ||
            (upd.phase != bytd_pkg::PH_PLAIN && upd.phase != bytd_pkg::PH_HEXHI);

      result.emit         = have || in_final;
      result.out_data     = byte_val;
      result.byte_present = have;
      result.value_end    = in_final;
      result.bad_value    = in_final && bad;

      if (in_final) begin
         nxt_state.phase   = bytd_pkg::PH_START;
         nxt_state.partial = 8'h00;
         nxt_state.failed  = 1'b0;
      end else begin
         nxt_state = upd;
      end
   end

endmodule

>>> rtl/bytea_text_decoder_core.sv
// Byte-string text decoder: hex and escape forms, one character per transfer.
// Characters that yield no byte and do not end a value produce no result.
// Throughput: one character per cycle unless the result side stalls, set by the single
// decode stage, whose output is registered in the result register before it is offered.
// Reset (synchronous, active high) empties both stages and returns to start of value.
// Depends on bytd_pkg, bytd_chan_if, bytd_step and bytea_text_decoder_core_assert.svh.
`include "bytea_text_decoder_core_assert.svh"

module bytea_text_decoder_core (
   input logic              clock,
   input logic              reset,
   bytd_req_if.sink         req_chan,
   bytd_rsp_if.source       rsp_chan
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [7:0]           s1_char_ff;
   logic                 s1_final_ff;
   bytd_pkg::state_type  state_ff, state_in;
   bytd_pkg::result_type step_result;
   logic                 rsp_valid_ff, rsp_valid_in;
   bytd_pkg::result_type rsp_ff;
   logic                 advance;
   logic                 req_take;

   // The decode stage moves forward whenever the result register is free or draining.
   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !s1_valid_ff || advance;

   bytd_step u_step (
      .cur_state (state_ff),
      .in_char   (s1_char_ff),
      .in_final  (s1_final_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !advance);
      if (advance) begin
         rsp_valid_in = step_result.emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{phase: bytd_pkg::PH_START, partial: 8'h00, failed: 1'b0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff  <= req_chan.in_char;
         s1_final_ff <= req_chan.in_final;
      end
      if (advance && step_result.emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_data     = rsp_ff.out_data;
   assign rsp_chan.byte_present = rsp_ff.byte_present;
   assign rsp_chan.value_end    = rsp_ff.value_end;
   assign rsp_chan.bad_value    = rsp_ff.bad_value;

   `BYTD_ASSERT_SAME(a_rsp_has_content, clock, reset, rsp_valid_ff,
                     rsp_ff.byte_present || rsp_ff.value_end,
                     "result transfer carries neither a byte nor a value end")
   `BYTD_ASSERT_SAME(a_bad_only_at_end, clock, reset, rsp_valid_ff && !rsp_ff.value_end,
                     !rsp_ff.bad_value, "error flag raised before the value end")
   `BYTD_ASSERT_SAME(a_empty_byte_zero, clock, reset, rsp_valid_ff && !rsp_ff.byte_present,
                     rsp_ff.out_data == 8'h00, "data nonzero on a result without a byte")
   `BYTD_ASSERT_NEXT(a_end_restarts, clock, reset, advance && s1_final_ff,
                     state_ff.phase == bytd_pkg::PH_START && !state_ff.failed,
                     "decoder state not restarted after the last character")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for bytea_text_decoder_core: directed table, then random values.
// Depends on bytd_pkg, bytd_chan_if and the decoder RTL.
module tb;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_CHARS = 1950;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
      logic       bad;
   } decoded_type;

   typedef enum logic [1:0] {
      ROW_MODEL  = 2'd0,
      ROW_RESULT = 2'd1,
      ROW_SILENT = 2'd2
   } row_kind_type;

   typedef struct packed {
      logic [7:0]   c;
      logic         fin;
      row_kind_type kind;
      decoded_type  want;
   } row_type;

   logic clock = 1'b0;
   logic reset;

   bytd_req_if req_bus ();
   bytd_rsp_if rsp_bus ();

   bytea_text_decoder_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #1 clock = ~clock;

   // Decoder copy kept by the testbench.
   bytd_pkg::phase_type dec_phase;
   logic [7:0] dec_partial;
   logic       dec_failed;

   decoded_type decoded_fifo[$];
   row_type     dir_rows[$];
   logic [7:0] value_chars[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  chars_sent = 0;
   int  values_done = 0;
   int  bytes_seen = 0;
   int  bad_seen = 0;
   bit  steady = 1'b0;
   int  rx_hold = 0;
   string hex_set = "0123456789abcdefABCDEF";

   function automatic logic [5:0] char_rank(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41 + 8'd10);
      if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd10);
      return bytd_pkg::NOT_DIGIT;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic clear_decoder();
      dec_phase = bytd_pkg::PH_START;
      dec_partial = 8'h00;
      dec_failed = 1'b0;
   endtask

   task automatic decode_char(input logic [7:0] c, input logic fin,
                              output logic emits, output decoded_type r);
      logic       have;
      logic [7:0] b;
      logic [5:0] v;
      have = 1'b0;
      b = 8'h00;
      v = char_rank(c);
      if (!dec_failed) begin
         case (dec_phase)
            bytd_pkg::PH_START: begin
               if (c == bytd_pkg::BSLASH) begin
                  dec_phase = bytd_pkg::PH_LEADBS;
               end else begin
                  have = 1'b1;
                  b = c;
                  dec_phase = bytd_pkg::PH_PLAIN;
               end
            end
            bytd_pkg::PH_LEADBS, bytd_pkg::PH_ESC1: begin
               // Only the very first backslash of a value can open hex mode.
               if (dec_phase == bytd_pkg::PH_LEADBS && c == bytd_pkg::LOWER_X) begin
                  dec_phase = bytd_pkg::PH_HEXHI;
               end else if (v < bytd_pkg::OCT_LIMIT) begin
                  dec_partial = {5'b0, v[2:0]};
                  dec_phase = bytd_pkg::PH_ESC2;
               end else if (c == bytd_pkg::BSLASH) begin
                  have = 1'b1;
                  b = bytd_pkg::BSLASH;
                  dec_phase = bytd_pkg::PH_PLAIN;
               end else begin
                  dec_failed = 1'b1;
               end
            end
            bytd_pkg::PH_HEXHI: begin
               dec_partial = {v[3:0], 4'b0};
               dec_phase = bytd_pkg::PH_HEXLO;
            end
            bytd_pkg::PH_HEXLO: begin
               have = 1'b1;
               b = dec_partial | {2'b0, v};
               dec_phase = bytd_pkg::PH_HEXHI;
            end
            bytd_pkg::PH_ESC2: begin
               if (v < bytd_pkg::OCT_LIMIT) begin
                  dec_partial = {dec_partial[4:0], v[2:0]};
                  dec_phase = bytd_pkg::PH_ESC3;
               end else begin
                  dec_failed = 1'b1;
               end
            end
            bytd_pkg::PH_ESC3: begin
               if (v < bytd_pkg::OCT_LIMIT) begin
                  have = 1'b1;
                  b = {dec_partial[4:0], v[2:0]};
                  dec_phase = bytd_pkg::PH_PLAIN;
               end else begin
                  dec_failed = 1'b1;
               end
            end
            default: begin
               if (c == bytd_pkg::BSLASH) begin
                  dec_phase = bytd_pkg::PH_ESC1;
               end else begin
                  have = 1'b1;
                  b = c;
               end
            end
         endcase
      end
      if (dec_failed) begin
         have = 1'b0;
         b = 8'h00;
      end
      r.data = b;
      r.present = have;
      r.last = fin;
      r.bad = 1'b0;
      emits = have | fin;
      if (fin) begin
         r.bad = dec_failed ||
                 !(dec_phase == bytd_pkg::PH_PLAIN || dec_phase == bytd_pkg::PH_HEXHI);
         clear_decoder();
      end
   endtask

   task automatic table_row(input logic [7:0] c, input logic fin, input row_kind_type kind,
                            input logic [7:0] d, input logic p, input logic l,
                            input logic b);
      row_type row;
      row.c = c;
      row.fin = fin;
      row.kind = kind;
      row.want.data = d;
      row.want.present = p;
      row.want.last = l;
      row.want.bad = b;
      dir_rows.push_back(row);
   endtask

   task automatic send_char(input logic [7:0] c, input logic fin, input row_kind_type kind,
                            input decoded_type want);
      logic        emits;
      decoded_type r;
      req_bus.valid <= 1'b1;
      req_bus.in_char <= c;
      req_bus.in_final <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      decode_char(c, fin, emits, r);
      if (kind == ROW_RESULT) decoded_fifo.push_back(want);
      else if (kind == ROW_MODEL && emits) decoded_fifo.push_back(r);
      chars_sent++;
   endtask

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (decoded_fifo.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] octal_char();
      return 8'h30 + 8'($urandom_range(0, 7));
   endfunction

   function automatic logic [7:0] hex_char();
      if ($urandom_range(0, 99) < 85) return hex_set[$urandom_range(0, 21)];
      return 8'($urandom_range(0, 255));
   endfunction

   // Fills value_chars with one random value: mostly well-formed hex or escape text.
   task automatic build_value();
      int mode;
      int n;
      int r;
      int k;
      logic [7:0] c;
      value_chars.delete();
      mode = $urandom_range(0, 99);
      if (mode < 35) begin
         value_chars.push_back(bytd_pkg::BSLASH);
         value_chars.push_back(bytd_pkg::LOWER_X);
         n = $urandom_range(0, 6);
         repeat (n) begin
            value_chars.push_back(hex_char());
            value_chars.push_back(hex_char());
         end
         if ($urandom_range(0, 9) == 0) value_chars.push_back(hex_char());
      end else if (mode < 85) begin
         n = $urandom_range(1, 8);
         repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               c = 8'($urandom_range(0, 255));
               value_chars.push_back(c == bytd_pkg::BSLASH ? 8'h41 : c);
            end else if (r < 70) begin
               value_chars.push_back(bytd_pkg::BSLASH);
               value_chars.push_back(bytd_pkg::BSLASH);
            end else if (r < 92) begin
               value_chars.push_back(bytd_pkg::BSLASH);
               repeat (3) value_chars.push_back(octal_char());
            end else begin
               value_chars.push_back(bytd_pkg::BSLASH);
               k = $urandom_range(0, 2);
               repeat (k) value_chars.push_back(octal_char());
               value_chars.push_back(8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 19) == 0) begin
            // Leave the value inside an escape.
            value_chars.push_back(bytd_pkg::BSLASH);
            k = $urandom_range(0, 2);
            repeat (k) value_chars.push_back(octal_char());
         end
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) begin
            if ($urandom_range(0, 9) < 3) value_chars.push_back(bytd_pkg::BSLASH);
            else value_chars.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Result side: random stalls, except during steady stretches.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            rx_hold = rx_hold - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 20) rx_hold = idle_len();
         end
      end
   end

   always @(posedge clock) begin : check_results
      decoded_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (decoded_fifo.size() == 0) begin
            $error("unexpected result transfer: out_data %h byte_present %b value_end %b",
                   rsp_bus.out_data, rsp_bus.byte_present, rsp_bus.value_end);
            error_count++;
         end else begin
            want = decoded_fifo.pop_front();
            if (rsp_bus.out_data !== want.data) begin
               $error("out_data: expected %h, got %h", want.data, rsp_bus.out_data);
               error_count++;
            end
            if (rsp_bus.byte_present !== want.present) begin
               $error("byte_present: expected %b, got %b", want.present,
                      rsp_bus.byte_present);
               error_count++;
            end
            if (rsp_bus.value_end !== want.last) begin
               $error("value_end: expected %b, got %b", want.last, rsp_bus.value_end);
               error_count++;
            end
            if (rsp_bus.bad_value !== want.bad) begin
               $error("bad_value: expected %b, got %b", want.bad, rsp_bus.bad_value);
               error_count++;
            end
            if (want.present) bytes_seen++;
            if (want.last) values_done++;
            if (want.last && want.bad) bad_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bytea_text_decoder_core regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      decoded_type none;
      bit          paused_once;
      int          random_sent;
      logic [7:0]  c;
      none = '0;
      paused_once = 1'b0;
      random_sent = 0;
      clear_decoder();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.in_char <= 8'h00;
      req_bus.in_final <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Lone backslash, byte extremes, bare hex prefix, odd hex length.
      table_row(bytd_pkg::BSLASH, 1'b1, ROW_RESULT, 8'h00, 1'b0, 1'b1, 1'b1);
      table_row(8'h00,  1'b1, ROW_RESULT, 8'h00, 1'b1, 1'b1, 1'b0);
      table_row(8'hFF,  1'b1, ROW_RESULT, 8'hFF, 1'b1, 1'b1, 1'b0);
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row(bytd_pkg::LOWER_X, 1'b1, ROW_RESULT, 8'h00, 1'b0, 1'b1, 1'b0);
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row(bytd_pkg::LOWER_X, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("z",    1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("!",    1'b0, ROW_MODEL,  8'h00, 1'b0, 1'b0, 1'b0);
      table_row("F",    1'b1, ROW_RESULT, 8'h00, 1'b0, 1'b1, 1'b1);
      // Escape mode: plain byte, doubled backslash, octal escape, then an invalid escape.
      table_row("a",    1'b0, ROW_MODEL,  8'h00, 1'b0, 1'b0, 1'b0);
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_MODEL,  8'h00, 1'b0, 1'b0, 1'b0);
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("3",    1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("7",    1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("7",    1'b0, ROW_MODEL,  8'h00, 1'b0, 1'b0, 1'b0);
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("q",    1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("b",    1'b1, ROW_RESULT, 8'h00, 1'b0, 1'b1, 1'b1);
      // Non-octal digit inside an escape, then an escape cut short by the end.
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("0",    1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("8",    1'b1, ROW_RESULT, 8'h00, 1'b0, 1'b1, 1'b1);
      table_row(bytd_pkg::BSLASH, 1'b0, ROW_SILENT, 8'h00, 1'b0, 1'b0, 1'b0);
      table_row("1",    1'b1, ROW_RESULT, 8'h00, 1'b0, 1'b1, 1'b1);

      foreach (dir_rows[i]) begin
         send_char(dir_rows[i].c, dir_rows[i].fin, dir_rows[i].kind, dir_rows[i].want);
         pause_sender(idle_len());
      end
      wait_drained();

      while (random_sent < RANDOM_CHARS) begin
         build_value();
         steady = ($urandom_range(0, 9) < 2);
         foreach (value_chars[i]) begin
            c = value_chars[i];
            send_char(c, i == value_chars.size() - 1, ROW_MODEL, none);
            random_sent++;
            if (!steady) pause_sender(idle_len());
         end
         // Hold off once until every transfer in flight has drained.
         if (!paused_once && random_sent > RANDOM_CHARS / 2) begin
            paused_once = 1'b1;
            wait_drained();
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Sent %0d characters; checked %0d values, %0d decoded bytes, %0d flagged bad.",
               chars_sent, values_done, bytes_seen, bad_seen);
      $display("Covered hex and escape forms, octal escapes, broken and cut-short values.");
      if (error_count == 0) begin
         $display("bytea_text_decoder_core regression: pass");
      end else begin
         $display("bytea_text_decoder_core regression: fail");
      end
      $finish;
   end

endmodule
